@@ design/chlz_pkg.sv @@
// ----------------------------------------------------------------------------
// chlz_pkg
// shared types, phase codes and command tables of the chunked lz/rle decoder
// ----------------------------------------------------------------------------
`default_nettype none

package chlz_pkg;

  localparam logic [2:0] PH_CMD     = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_OPS     = 3'd2;
  localparam logic [2:0] PH_RUN     = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;
  localparam logic [2:0] PH_ERR_OFS = 3'd5;
  localparam logic [2:0] PH_ERR_IN  = 3'd6;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_OFS    = 2'd1;
  localparam logic [1:0] ERR_INPUT  = 2'd2;
  localparam logic [1:0] ERR_FEED   = 2'd3;

  localparam logic       REQ_FEED   = 1'b0;
  localparam logic       CFG_CHUNKS = 1'b0;
  localparam logic       CFG_LIMIT  = 1'b1;

  localparam logic [15:0] LIMIT_RESET = 16'hc000;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
    logic       in_last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       need_input;
    logic       done_res;
    logic [1:0] error_code;
  } res_t;

  // decoder state
  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  command;
    logic [15:0] run_length;
    logic [7:0]  op0;
    logic [7:0]  op1;
    logic [7:0]  op2;
    logic [15:0] copy_offset;
    logic [1:0]  sub_position;
    logic        ended;
    logic        held;
    logic [15:0] chunks_left;
    logic [16:0] out_count;
  } st_t;

  // one accepted item as seen by the datapath
  typedef struct packed {
    logic        emit;
    logic        copy;
    logic [7:0]  value;
    logic [16:0] rd_pos;
    logic [16:0] wr_pos;
    logic        need_input;
    logic        done_res;
    logic [1:0]  error_code;
  } step_t;

  function automatic logic [1:0] ops_need(input logic [3:0] g);
    case (g)
      4'd3, 4'd7, 4'd8, 4'd9, 4'd10: ops_need = 2'd1;
      4'd4, 4'd5, 4'd11:             ops_need = 2'd2;
      4'd6:                          ops_need = 2'd3;
      default:                       ops_need = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] unit_len(input logic [3:0] g);
    case (g)
      4'd5, 4'd7, 4'd9: unit_len = 2'd2;
      4'd6, 4'd8:       unit_len = 2'd3;
      default:          unit_len = 2'd1;
    endcase
  endfunction

  function automatic logic [3:0] in_slots(input logic [3:0] g);
    case (g)
      4'd0, 4'd9: in_slots = 4'd1;
      4'd7:       in_slots = 4'd2;
      4'd8:       in_slots = 4'd6;
      default:    in_slots = 4'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ design/chlz_hist.sv @@
// ----------------------------------------------------------------------------
// chlz_hist
// decoded byte history ring, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module chlz_hist #(
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/chlz_ctrl.sv @@
// ----------------------------------------------------------------------------
// chlz_ctrl
// command decode and run sequencing, one request per transfer
// ----------------------------------------------------------------------------
`default_nettype none

module chlz_ctrl
  import chlz_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        acc,
  input  wire item_t       item,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  output step_t            step
);

  st_t         st;
  st_t         st_next;
  st_t         st_cfg;
  logic [15:0] size_limit;

  function automatic logic wants(input st_t t);
    logic [3:0] g;
    logic [3:0] sl;
    g  = t.command[4:1];
    sl = in_slots(g);
    case (t.phase)
      PH_CMD, PH_LEN: wants = 1'b1;
      PH_OPS:         wants = t.sub_position < ops_need(g);
      PH_RUN:         wants = sl[t.sub_position] && !t.held;
      default:        wants = 1'b0;
    endcase
  endfunction

  function automatic st_t settle(input st_t s, input logic [15:0] lim);
    st_t        t;
    logic [3:0] g;
    logic       bad;
    t   = s;
    g   = t.command[4:1];
    bad = 1'b0;
    if (t.phase == PH_OPS && t.sub_position >= ops_need(g)) begin
      t.sub_position = 2'd0;
      if (g == 4'd10) t.copy_offset = {8'd0, t.op0};
      else if (g == 4'd11) t.copy_offset = {t.op0, t.op1};
      if (g >= 4'd10 && (t.copy_offset == 16'd0 || {1'b0, t.copy_offset} > t.out_count)) begin
        t.phase = PH_ERR_OFS;
        bad     = 1'b1;
      end else begin
        t.phase = PH_RUN;
      end
    end
    if (!bad) begin
      if (t.phase == PH_RUN && t.run_length == 16'd0) t.phase = PH_CMD;
      if (t.phase == PH_CMD && (t.chunks_left == 16'd0 || t.out_count >= {1'b0, lim}))
        t.phase = PH_DONE;
      if (wants(t) && t.ended) t.phase = PH_ERR_IN;
    end
    return t;
  endfunction

  st_t        a;
  st_t        n;
  st_t        f;
  logic [3:0] g;
  logic [1:0] sidx;
  logic [1:0] sub_inc;
  logic       feed_err;

  always_comb begin
    a        = settle(st, size_limit);
    n        = a;
    g        = a.command[4:1];
    sidx     = (a.sub_position == 2'd3) ? 2'd0 : a.sub_position;
    sub_inc  = a.sub_position + 2'd1;
    feed_err = 1'b0;
    step     = '0;
    if (item.req_type == REQ_FEED) begin
      if (wants(a)) begin
        case (a.phase)
          PH_CMD: begin
            n.command      = item.in_byte;
            n.chunks_left  = a.chunks_left - 16'd1;
            n.sub_position = 2'd0;
            n.run_length   = {13'd0, item.in_byte[7:5]} + 16'd3;
            if (item.in_byte[4:1] >= 4'd12 || item.in_byte[0]) begin
              n.phase = PH_LEN;
            end else begin
              case (item.in_byte[4:0])
                5'h00:                      n.run_length = n.run_length - 16'd2;
                5'h02, 5'h04, 5'h0a, 5'h0c: n.run_length = n.run_length - 16'd1;
                5'h08, 5'h16:               n.run_length = n.run_length + 16'd1;
                default: ;
              endcase
              n.phase = PH_OPS;
            end
          end
          PH_LEN: begin
            if (g >= 4'd12) n.copy_offset = {5'd0, a.command[2:0], item.in_byte};
            else n.run_length = {5'd0, a.command[7:5], item.in_byte};
            n.sub_position = 2'd0;
            n.phase        = PH_OPS;
          end
          PH_OPS: begin
            case (sidx)
              2'd0:    n.op0 = item.in_byte;
              2'd1:    n.op1 = item.in_byte;
              default: n.op2 = item.in_byte;
            endcase
            n.sub_position = sub_inc;
          end
          PH_RUN: begin
            if (g == 4'd9) n.op1 = item.in_byte;
            else n.op2 = item.in_byte;
            n.held = 1'b1;
          end
          default: ;
        endcase
        if (item.in_last) n.ended = 1'b1;
      end else begin
        feed_err = 1'b1;
      end
    end else if (a.phase == PH_RUN && !wants(a)) begin
      step.emit = 1'b1;
      step.copy = g >= 4'd10;
      case (g)
        4'd0: step.value = a.op2;
        4'd1: step.value = 8'h00;
        4'd2: step.value = 8'hff;
        4'd3: step.value = a.op0;
        4'd4: begin
          step.value = a.op0;
          n.op0      = a.op0 + a.op1;
        end
        4'd5, 4'd6: begin
          case (sidx)
            2'd0:    step.value = a.op0;
            2'd1:    step.value = a.op1;
            default: step.value = a.op2;
          endcase
        end
        4'd7, 4'd8: step.value = (sidx == 2'd0) ? a.op0 : a.op2;
        4'd9: step.value = a.op0 + ((sidx == 2'd0) ? {4'd0, a.op1[7:4]} : {4'd0, a.op1[3:0]});
        default: step.value = 8'h00;
      endcase
      step.wr_pos    = a.out_count;
      step.rd_pos    = a.out_count - {1'b0, a.copy_offset};
      n.out_count    = a.out_count + 17'd1;
      n.held         = 1'b0;
      n.sub_position = sub_inc;
      if (sub_inc >= unit_len(g)) begin
        n.sub_position = 2'd0;
        n.run_length   = a.run_length - 16'd1;
      end
    end
    f               = settle(n, size_limit);
    st_next         = f;
    step.need_input = wants(f);
    step.done_res   = f.phase == PH_DONE;
    if (f.phase == PH_ERR_OFS) step.error_code = ERR_OFS;
    else if (f.phase == PH_ERR_IN) step.error_code = ERR_INPUT;
    else if (feed_err) step.error_code = ERR_FEED;
    else step.error_code = ERR_NONE;
  end

  // chunk count write reloads the counter and wakes a finished decoder
  always_comb begin
    st_cfg             = st;
    st_cfg.chunks_left = cfg_data;
    if (st.phase == PH_DONE) st_cfg.phase = PH_CMD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= '{phase: PH_CMD, default: '0};
      size_limit    <= LIMIT_RESET;
    end else if (acc) begin
      st <= st_next;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CHUNKS) begin
        st <= st_cfg;
      end else begin
        size_limit <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/chunk_lz_rle_decompressor_unit.sv @@
// ----------------------------------------------------------------------------
// chunk_lz_rle_decompressor_unit
// pull-driven chunked lz/rle decoder with an on-chip history ring
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   in_data   (item_t: feed or advance)
// res       output     res_valid / res_ready res_data  (res_t: one per request)
// cfg       input      cfg_we                cfg_index, cfg_data
//
// every request passes the decoder and then the registered history read stage
// before its result enters the output queue; one request per cycle is sustained
// while res_ready stays high, served by the single history write/read port pair.
// reset is synchronous; the history ring is not cleared, copies only read
// written entries. a 2-entry output queue absorbs stalls on res_ready, and
// in_ready drops when the queue and the read stage together hold two results
// and none leaves in that cycle.
// HISTORY_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_lz_rle_decompressor_unit
  import chlz_pkg::*;
#(
  parameter int HISTORY_DEPTH = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire item_t       in_data,
  output logic             res_valid,
  input  wire logic        res_ready,
  output res_t             res_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  step_t          step;
  logic           acc;

  // read stage
  logic           s1_valid;
  step_t          s1;
  logic           s1_fwd;
  logic [7:0]     s1_fwd_data;
  logic [7:0]     rdata;
  logic [7:0]     s1_byte;
  res_t           s1_res;

  // output queue
  logic [1:0]     fifo_cnt;
  res_t           q0;
  res_t           q1;
  logic           res_pop;

  assign acc     = in_valid && in_ready;
  assign res_pop = res_valid && res_ready;
  assign in_ready = ({1'b0, fifo_cnt} + {2'd0, s1_valid}) <= (3'd1 + {2'd0, res_pop});

  chlz_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .item      (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step)
  );

  // the item in the read stage writes at the same edge a new copy reads
  chlz_hist #(.AW(AW)) u_hist (
    .clk   (clk),
    .we    (s1_valid && s1.emit),
    .waddr (s1.wr_pos[AW-1:0]),
    .wdata (s1_byte),
    .re    (acc),
    .raddr (step.rd_pos[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    if (s1.copy) s1_byte = s1_fwd ? s1_fwd_data : rdata;
    else s1_byte = s1.value;
    s1_res.out_byte   = s1.emit ? s1_byte : 8'h00;
    s1_res.out_valid  = s1.emit;
    s1_res.need_input = s1.need_input;
    s1_res.done_res   = s1.done_res;
    s1_res.error_code = s1.error_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else begin
      s1_valid <= acc;
      if (acc) begin
        s1_fwd <= s1_valid && s1.emit && (s1.wr_pos[AW-1:0] == step.rd_pos[AW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1          <= step;
      s1_fwd_data <= s1_byte;
    end
  end

  // output queue, head in q0
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_cnt <= 2'd0;
    end else begin
      case ({s1_valid, res_pop})
        2'b10: begin
          if (fifo_cnt == 2'd0) q0 <= s1_res;
          else q1 <= s1_res;
          fifo_cnt <= fifo_cnt + 2'd1;
        end
        2'b01: begin
          q0       <= q1;
          fifo_cnt <= fifo_cnt - 2'd1;
        end
        2'b11: begin
          if (fifo_cnt == 2'd1) begin
            q0 <= s1_res;
          end else begin
            q0 <= q1;
            q1 <= s1_res;
          end
        end
        default: ;
      endcase
    end
  end

  assign res_valid = fifo_cnt != 2'd0;
  assign res_data  = q0;

  // queue never overflows
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !res_pop |-> fifo_cnt != 2'd2)
    else $error("output queue overflow");

  // every transfer enters the read stage next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted request lost");

  // forwarding only follows an item that was in the read stage
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_fwd |-> $past(s1_valid))
    else $error("forward without producer");

endmodule

`default_nettype wire

@@ verif/chunk_lz_rle_decompressor_unit_tb.sv @@
// ----------------------------------------------------------------------------
// chunk_lz_rle_decompressor_unit_tb
// self-checking bench: drives feed and advance requests into the decoder,
// predicts every result from its own model of the format and compares each
// result transfer field by field, under random stalls on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_lz_rle_decompressor_unit_tb;
  import chlz_pkg::*;

  localparam int WD_LIMIT = 4000;
  // per-kind tables: operand count (2 bits), unit length (2 bits), literal slots (4 bits)
  localparam logic [31:0] OPS_NEED_V = 32'h0095_7a40;
  localparam logic [31:0] UNIT_LEN_V = 32'h555b_b955;
  localparam logic [63:0] LIT_SLOT_V = 64'h0000_0016_2000_0001;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  item_t in_data;
  logic  res_valid;
  logic  res_ready;
  res_t  res_data;
  logic  cfg_we;
  logic  cfg_index;
  logic [15:0] cfg_data;

  chunk_lz_rle_decompressor_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // decoder image kept by the bench
  logic [2:0]  ph;
  logic [7:0]  cmd_r;
  logic [15:0] run_left;
  logic [7:0]  opnd [3];
  logic [15:0] ofs;
  logic [1:0]  sub;
  logic        ended_f;
  logic        held_f;
  logic [15:0] chunks_r;
  logic [15:0] limit_r;
  logic [16:0] produced;
  logic [7:0]  hist [0:65535];

  res_t expected_q [$];
  int   errors;
  int   items_sent;
  int   results_seen;
  int   bytes_seen;
  int   idle_cyc;
  int   hold_seq;
  int   hold_seen;
  int   stall_left;
  bit   quiet;

  function automatic bit pct(input int p);
    return $urandom_range(0, 99) < p;
  endfunction

  function automatic logic [1:0] need_of(input logic [3:0] g);
    return OPS_NEED_V[2*g +: 2];
  endfunction

  function automatic logic [1:0] unit_of(input logic [3:0] g);
    return UNIT_LEN_V[2*g +: 2];
  endfunction

  function automatic bit wants_byte();
    logic [3:0] g;
    g = cmd_r[4:1];
    case (ph)
      PH_CMD, PH_LEN: return 1'b1;
      PH_OPS:         return sub < need_of(g);
      PH_RUN:         return LIT_SLOT_V[4*g + sub] && !held_f;
      default:        return 1'b0;
    endcase
  endfunction

  // advance the phase past anything that needs no request
  function automatic void settle();
    logic [3:0] g;
    bit go;
    go = 1'b1;
    while (go) begin
      g  = cmd_r[4:1];
      go = 1'b0;
      if (ph == PH_CMD) begin
        if (chunks_r == 0 || produced >= {1'b0, limit_r}) ph = PH_DONE;
      end else if (ph == PH_OPS && sub >= need_of(g)) begin
        sub = 0;
        if (g == 4'd10) ofs = {8'h00, opnd[0]};
        else if (g == 4'd11) ofs = {opnd[0], opnd[1]};
        if (g >= 4'd10 && (ofs == 0 || {1'b0, ofs} > produced)) begin
          ph = PH_ERR_OFS;
          return;
        end
        ph = PH_RUN;
        go = 1'b1;
      end else if (ph == PH_RUN && run_left == 0) begin
        ph = PH_CMD;
        go = 1'b1;
      end
    end
    if (wants_byte() && ended_f) ph = PH_ERR_IN;
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    logic [3:0] g;
    g = cmd_r[4:1];
    case (ph)
      PH_CMD: begin
        cmd_r    = b;
        chunks_r = chunks_r - 1'b1;
        sub      = 0;
        run_left = {13'd0, b[7:5]} + 16'd3;
        if (b[4:1] >= 4'd12 || b[0]) begin
          ph = PH_LEN;
        end else begin
          case (b[4:0])
            5'h00:                      run_left = run_left - 16'd2;
            5'h02, 5'h04, 5'h0a, 5'h0c: run_left = run_left - 16'd1;
            5'h08, 5'h16:               run_left = run_left + 16'd1;
            default: ;
          endcase
          ph = PH_OPS;
        end
      end
      PH_LEN: begin
        if (g >= 4'd12) ofs = {5'd0, cmd_r[2:0], b};
        else run_left = {5'd0, cmd_r[7:5], b};
        sub = 0;
        ph  = PH_OPS;
      end
      PH_OPS: begin
        opnd[sub % 3] = b;
        sub = sub + 1'b1;
      end
      PH_RUN: begin
        if (g == 4'd9) opnd[1] = b;
        else opnd[2] = b;
        held_f = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] emit_byte();
    logic [3:0] g;
    logic [1:0] s;
    logic [7:0] v;
    g = cmd_r[4:1];
    s = sub % 3;
    case (g)
      4'd0: v = opnd[2];
      4'd1: v = 8'h00;
      4'd2: v = 8'hff;
      4'd3: v = opnd[0];
      4'd4: begin
        v = opnd[0];
        opnd[0] = opnd[0] + opnd[1];
      end
      4'd5, 4'd6: v = opnd[s];
      4'd7, 4'd8: v = (s == 0) ? opnd[0] : opnd[2];
      4'd9: v = opnd[0] + {4'd0, (s == 0) ? opnd[1][7:4] : opnd[1][3:0]};
      default: v = hist[produced[15:0] - ofs];
    endcase
    hist[produced[15:0]] = v;
    produced = produced + 1'b1;
    held_f   = 1'b0;
    sub      = sub + 1'b1;
    if (sub >= unit_of(g)) begin
      sub      = 0;
      run_left = run_left - 1'b1;
    end
    return v;
  endfunction

  function automatic res_t decode_step(input item_t it);
    res_t r;
    r = '0;
    settle();
    if (it.req_type == REQ_FEED) begin
      if (wants_byte()) begin
        take_byte(it.in_byte);
        if (it.in_last) ended_f = 1'b1;
      end else begin
        r.error_code = ERR_FEED;
      end
    end else if (ph == PH_RUN && !wants_byte()) begin
      r.out_byte  = emit_byte();
      r.out_valid = 1'b1;
    end
    settle();
    if (ph == PH_ERR_OFS) r.error_code = ERR_OFS;
    else if (ph == PH_ERR_IN) r.error_code = ERR_INPUT;
    r.need_input = wants_byte();
    r.done_res   = (ph == PH_DONE);
    return r;
  endfunction

  // one item over the input channel; called at a falling edge, returns at one
  task automatic send(input item_t it);
    int gap;
    gap = 0;
    if (!quiet) begin
      if (pct(5)) gap = $urandom_range(8, 30);
      else if (pct(25)) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(decode_step(it));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic feed(input logic [7:0] b, input logic last);
    item_t it;
    it.req_type = REQ_FEED;
    it.in_byte  = b;
    it.in_last  = last;
    send(it);
  endtask

  task automatic advance();
    item_t it;
    it.req_type = ~REQ_FEED;
    it.in_byte  = 8'($urandom);
    it.in_last  = 1'($urandom);
    send(it);
  endtask

  // pull out every byte that needs no further input
  task automatic drain_run();
    while (ph == PH_RUN && !wants_byte()) advance();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CHUNKS) begin
      chunks_r = val;
      if (ph == PH_DONE) ph = PH_CMD;
    end else begin
      limit_r = val;
    end
    @(negedge clk);
  endtask

  task automatic run_chunk(input logic [7:0] bytes [$]);
    foreach (bytes[i]) begin
      drain_run();
      feed(bytes[i], 1'b0);
    end
    drain_run();
  endtask

  function automatic int min_int(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // low offset byte that keeps a back-reference inside the written history
  function automatic logic [7:0] low_offset(input int hi);
    int lo_min;
    lo_min = (hi == 0) ? 1 : 0;
    return 8'($urandom_range(lo_min, min_int(255, int'(produced) - hi * 256)));
  endfunction

  function automatic logic [7:0] pick_command();
    logic [3:0] g;
    logic [2:0] cnt;
    int ofs_pick;
    g = 4'($urandom);
    if (produced == 0 && g >= 4'd10) g = 4'd0;
    if (g >= 4'd12) begin
      ofs_pick = $urandom_range(1, min_int(int'(produced), 2047));
      cnt = 3'($urandom);
      return {cnt, 2'b11, 3'(ofs_pick >> 8)};
    end
    if (pct(30)) begin
      cnt = pct(97) ? 3'd0 : 3'd1;
      return {cnt, g, 1'b1};
    end
    return {3'($urandom), g, 1'b0};
  endfunction

  // next compressed byte, well formed for the current decoder phase
  function automatic logic [7:0] pick_byte();
    logic [3:0] g;
    int ofs_pick;
    g = cmd_r[4:1];
    case (ph)
      PH_CMD: return pick_command();
      PH_LEN: begin
        if (g >= 4'd12) return low_offset(cmd_r[2:0]);
        if (cmd_r[7:5] == 0 && pct(8)) return 8'($urandom);
        return 8'($urandom_range(0, 10));
      end
      PH_OPS: begin
        if (g == 4'd10) return 8'($urandom_range(1, min_int(int'(produced), 255)));
        if (g == 4'd11 && sub == 0) begin
          ofs_pick = $urandom_range(1, min_int(int'(produced), 65535));
          return 8'(ofs_pick >> 8);
        end
        if (g == 4'd11) return low_offset(opnd[0]);
        return 8'($urandom);
      end
      default: return 8'($urandom);
    endcase
  endfunction

  // decode until done or an error phase, mostly well-formed bytes with some stray requests
  task automatic run_stream(input int pause_at);
    int n;
    n = 0;
    while (ph != PH_DONE && ph != PH_ERR_OFS && ph != PH_ERR_IN) begin
      if (n == pause_at) wait_drained();
      if (pct(5)) begin
        if (wants_byte()) advance();
        else feed(8'($urandom), 1'($urandom));
      end else if (wants_byte()) begin
        feed(pick_byte(), 1'b0);
      end else begin
        advance();
      end
      n++;
    end
  endtask

  // result side: random stalls plus a long hold on request
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen  = hold_seq;
      stall_left = 120;
    end
    if (stall_left > 0) begin
      stall_left--;
      res_ready <= 1'b0;
    end else if (!quiet && pct(12)) begin
      stall_left = pct(85) ? $urandom_range(0, 2) : $urandom_range(10, 30);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // compare every result transfer against the oldest expectation
  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (res_data.out_valid) bytes_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_data);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (res_data.out_byte !== exp_r.out_byte) begin
          $display("%0t: out_byte exp %h got %h", $time, exp_r.out_byte, res_data.out_byte);
          errors++;
        end
        if (res_data.out_valid !== exp_r.out_valid) begin
          $display("%0t: out_valid exp %b got %b", $time, exp_r.out_valid, res_data.out_valid);
          errors++;
        end
        if (res_data.need_input !== exp_r.need_input) begin
          $display("%0t: need_input exp %b got %b", $time, exp_r.need_input,
                   res_data.need_input);
          errors++;
        end
        if (res_data.done_res !== exp_r.done_res) begin
          $display("%0t: done_res exp %b got %b", $time, exp_r.done_res, res_data.done_res);
          errors++;
        end
        if (res_data.error_code !== exp_r.error_code) begin
          $display("%0t: error_code exp %0d got %0d", $time, exp_r.error_code,
                   res_data.error_code);
          errors++;
        end
      end
    end
  end

  // end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (res_valid && res_ready)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc == WD_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WD_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // after reset nothing is configured: stray feeds and advances while done
  task automatic test_idle_after_reset();
    advance();
    feed(8'hff, 1'b0);
    feed(8'h00, 1'b1);
    advance();
  endtask

  // a zero size limit stops decoding before the first chunk
  task automatic test_zero_limit();
    write_reg(CFG_LIMIT, 16'd0);
    write_reg(CFG_CHUNKS, 16'd5);
    advance();
    feed(8'h01, 1'b0);
    write_reg(CFG_LIMIT, LIMIT_RESET);
    write_reg(CFG_CHUNKS, 16'd0);
  endtask

  // one chunk of every kind, zero-length runs and overlapping copies
  task automatic test_every_kind();
    quiet = 1'b1;
    write_reg(CFG_CHUNKS, 16'd17);
    run_chunk('{8'h00, 8'h00});
    run_chunk('{8'h01, 8'h03, 8'hff, 8'h80, 8'h7f});
    run_chunk('{8'h02});
    run_chunk('{8'he4});
    run_chunk('{8'h06, 8'h5a});
    run_chunk('{8'h08, 8'hfe, 8'h03});
    run_chunk('{8'h0a, 8'h12, 8'h34});
    run_chunk('{8'h0c, 8'h01, 8'h02, 8'h03});
    run_chunk('{8'h0e, 8'hc3, 8'h11, 8'h22, 8'h33});
    run_chunk('{8'h10, 8'h44, 8'ha1, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6});
    run_chunk('{8'h12, 8'hf0, 8'hab, 8'h0f, 8'he7});
    run_chunk('{8'h14, 8'h05});
    run_chunk('{8'h16, 8'h00, 8'h0a});
    run_chunk('{8'h18, 8'h10});
    run_chunk('{8'h01, 8'h00});
    run_chunk('{8'h15, 8'h00, 8'h01});
    run_chunk('{8'h34, 8'h01});
    advance();
    quiet = 1'b0;
  endtask

  // receiver holds off long enough to fill the decoder, then a sender pause
  task automatic test_backpressure();
    write_reg(CFG_CHUNKS, 16'd12);
    hold_seq++;
    run_stream(40);
  endtask

  // full chunk count, stopped by the size limit instead
  task automatic test_chunk_cap();
    write_reg(CFG_CHUNKS, 16'd49152);
    write_reg(CFG_LIMIT, 16'(produced + $urandom_range(50, 200)));
    run_stream(-1);
    write_reg(CFG_LIMIT, LIMIT_RESET);
  endtask

  task automatic test_random_streams();
    int phase_n;
    phase_n = 0;
    while (items_sent < 1150) begin
      quiet = (phase_n % 4 == 3);
      if (pct(25)) write_reg(CFG_LIMIT, 16'(produced + $urandom_range(0, 300)));
      else write_reg(CFG_LIMIT, LIMIT_RESET);
      write_reg(CFG_CHUNKS, 16'($urandom_range(3, 30)));
      run_stream(pct(10) ? $urandom_range(5, 30) : -1);
      phase_n++;
    end
    quiet = 1'b0;
    write_reg(CFG_LIMIT, LIMIT_RESET);
  endtask

  // zero offset on the final byte: sticky bad-offset error from then on
  task automatic test_bad_offset();
    write_reg(CFG_CHUNKS, 16'd1);
    feed(8'h14, 1'b0);
    feed(8'h00, 1'b1);
    advance();
    feed(8'h55, 1'b0);
    advance();
  endtask

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    res_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_CHUNKS;
    cfg_data   = '0;
    errors     = 0;
    items_sent = 0;
    idle_cyc   = 0;
    hold_seq   = 0;
    hold_seen  = 0;
    stall_left = 0;
    quiet      = 1'b0;
    // model state matching reset
    ph = PH_CMD;
    cmd_r = '0;
    run_left = '0;
    opnd = '{default: 8'h00};
    ofs = '0;
    sub = '0;
    ended_f = 1'b0;
    held_f = 1'b0;
    chunks_r = '0;
    limit_r = LIMIT_RESET;
    produced = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_idle_after_reset();
    test_zero_limit();
    test_every_kind();
    test_backpressure();
    test_chunk_cap();
    test_random_streams();
    test_bad_offset();

    wait_drained();
    $display("covered %0d requests, %0d results, %0d decoded bytes,", items_sent,
             results_seen, bytes_seen);
    $display("every command kind, size-limit and chunk-count stops, stalls and offset error");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ chunk_lz_rle_decompressor_unit.f @@
design/chlz_pkg.sv
design/chlz_hist.sv
design/chlz_ctrl.sv
design/chunk_lz_rle_decompressor_unit.sv
verif/chunk_lz_rle_decompressor_unit_tb.sv
